// ===== hdl/mmio_write_event_match_table_defines.svh =====
// Assertion macros for the trapped-write match table.
`ifndef MMIO_WRITE_EVENT_MATCH_TABLE_DEFINES_SVH
`define MMIO_WRITE_EVENT_MATCH_TABLE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define MWEM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MWEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/mwem_pkg.sv =====
// Package of types, codes and helpers for the trapped-write match table.
package mwem_pkg;
  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned EventIdBitsDef = 16;

  localparam logic [1:0] OpAssign = 2'd0;
  localparam logic [1:0] OpDeassign = 2'd1;
  localparam logic [1:0] OpLookup = 2'd2;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StInvalid = 3'd1;
  localparam logic [2:0] StExists = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] address;
    logic [3:0]  access_len;
    logic [63:0] data_value;
    logic        match_data;
    logic        port_io;
    logic        unknown_flags;
    logic [15:0] event_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [15:0] hit_event;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, clear scan flags
    logic step;      // examine current entry, advance index
    logic finish;    // form result, commit table change
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;      // current index is the last entry
    logic bypass;    // request needs no scan
  } sts_t;

  function automatic logic [63:0] len_mask(input logic [3:0] len);
    logic [63:0] m;
    case (len)
      4'd1: m = 64'h0000_0000_0000_00ff;
      4'd2: m = 64'h0000_0000_0000_ffff;
      4'd4: m = 64'h0000_0000_ffff_ffff;
      default: m = '1;
    endcase
    return m;
  endfunction
endpackage

// ===== hdl/mwem_ctrl.sv =====
// Controller state machine sequencing the table scan.
module mwem_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  mwem_pkg::sts_t  sts_i,
  output mwem_pkg::cmd_t  cmd_o
);
  mwem_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mwem_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register is free when empty or being drained this cycle.
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mwem_pkg::S_IDLE: if (in_valid_i) state_d = mwem_pkg::S_SCAN;
      mwem_pkg::S_SCAN: if (sts_i.bypass || sts_i.last) state_d = mwem_pkg::S_DONE;
      mwem_pkg::S_DONE: if (out_free) state_d = mwem_pkg::S_IDLE;
      default: state_d = mwem_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      mwem_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      mwem_pkg::S_SCAN: cmd_o.step = !sts_i.bypass;
      mwem_pkg::S_DONE: begin
        cmd_o.finish = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
endmodule

// ===== hdl/mwem_datapath.sv =====
// Datapath: entry store, entry comparator and result register.
module mwem_datapath #(
  parameter int unsigned TableEntries = mwem_pkg::TableEntriesDef,
  parameter int unsigned EventIdBits = mwem_pkg::EventIdBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mwem_pkg::req_t in_data_i,
  output mwem_pkg::rsp_t out_data_o,
  input  mwem_pkg::cmd_t cmd_i,
  output mwem_pkg::sts_t sts_o,
  output logic           any_free_o
);
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);
  localparam logic [IdxW-1:0] FirstIdx = '0;

  logic [TableEntries-1:0] valid_q;
  logic [63:0]            addr_mem [TableEntries];
  logic [3:0]             len_mem  [TableEntries];
  logic                   wild_mem [TableEntries];
  logic [63:0]            val_mem  [TableEntries];
  logic [EventIdBits-1:0] ev_mem   [TableEntries];

  mwem_pkg::req_t   req_q;
  logic [IdxW-1:0]  idx_q;
  logic             found_q;     // collision, deassign match or lookup hit
  logic [IdxW-1:0]  found_idx_q;
  logic [EventIdBits-1:0] found_ev_q;
  logic             free_q;
  logic [IdxW-1:0]  free_idx_q;
  logic             args_ok_q;
  mwem_pkg::rsp_t   rsp_q, rsp_d;

  // Entry under comparison, registered from the store ahead of the scan step that examines it.
  logic [63:0]            e_addr_q, e_val_q;
  logic [3:0]             e_len_q;
  logic                   e_wild_q;
  logic [EventIdBits-1:0] e_ev_q;

  // Argument validation on the incoming word.
  logic args_ok_d;
  logic [64:0] end_sum;
  always_comb begin
    end_sum = {1'b0, in_data_i.address} + 65'(in_data_i.access_len);
    args_ok_d = (in_data_i.access_len == 4'd0 || in_data_i.access_len == 4'd1 ||
                 in_data_i.access_len == 4'd2 || in_data_i.access_len == 4'd4 ||
                 in_data_i.access_len == 4'd8) && !end_sum[64] &&
                !in_data_i.unknown_flags && !in_data_i.port_io &&
                !(in_data_i.access_len == 4'd0 && in_data_i.match_data);
  end

  logic is_mod;
  logic at_last;
  logic [IdxW-1:0] nxt_idx;
  assign is_mod = req_q.operation == mwem_pkg::OpAssign ||
                  req_q.operation == mwem_pkg::OpDeassign;
  assign at_last = idx_q == LastIdx;
  assign nxt_idx = idx_q + IdxW'(1);
  assign sts_o.bypass = (is_mod && !args_ok_q) ||
                        !(is_mod || req_q.operation == mwem_pkg::OpLookup);
  assign sts_o.last = at_last;

  // Table changes made when the result is formed.
  logic do_insert, do_remove;
  assign do_insert = cmd_i.finish && args_ok_q && req_q.operation == mwem_pkg::OpAssign &&
                     free_q && !found_q;
  assign do_remove = cmd_i.finish && args_ok_q && req_q.operation == mwem_pkg::OpDeassign &&
                     found_q;

  // Compare the request against the entry at the scan index.
  logic [63:0] diff;
  logic        e_valid, wild, m;
  logic [EventIdBits-1:0] ev_in;
  always_comb begin
    e_valid = valid_q[idx_q];
    wild = !req_q.match_data;
    ev_in = req_q.event_id[EventIdBits-1:0];
    diff = req_q.address - e_addr_q;
    m = 1'b0;
    case (req_q.operation)
      mwem_pkg::OpAssign:
        m = (e_addr_q == req_q.address && (e_len_q == 4'd0 || req_q.access_len == 4'd0 ||
             (e_len_q == req_q.access_len &&
              (e_wild_q || wild || e_val_q == req_q.data_value))))
            || (req_q.address >= e_addr_q && diff < 64'(e_len_q));
      mwem_pkg::OpDeassign:
        m = e_ev_q == ev_in && e_addr_q == req_q.address && e_len_q == req_q.access_len &&
            e_wild_q == wild && (wild || e_val_q == req_q.data_value);
      default:
        m = e_addr_q == req_q.address && (e_len_q == 4'd0 || (e_len_q == req_q.access_len &&
            (e_wild_q ||
             (req_q.data_value & mwem_pkg::len_mask(req_q.access_len)) == e_val_q)));
    endcase
    m = m && e_valid;
  end

  // Result of the finished request.
  always_comb begin
    rsp_d = '0;
    if (!is_mod && req_q.operation != mwem_pkg::OpLookup) rsp_d.status = mwem_pkg::StInvalid;
    else if (is_mod && !args_ok_q) rsp_d.status = mwem_pkg::StInvalid;
    else if (req_q.operation == mwem_pkg::OpAssign) begin
      if (!free_q) rsp_d.status = mwem_pkg::StFull;
      else if (found_q) rsp_d.status = mwem_pkg::StExists;
    end else if (req_q.operation == mwem_pkg::OpDeassign) begin
      if (!found_q) rsp_d.status = mwem_pkg::StNotFound;
    end else if (found_q) begin
      rsp_d.hit = 1'b1;
      rsp_d.hit_event = 16'(found_ev_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (do_insert) begin
      valid_q[free_idx_q] <= 1'b1;
    end else if (do_remove) begin
      valid_q[found_idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
      args_ok_q <= args_ok_d;
      idx_q <= '0;
      found_q <= 1'b0;
      free_q <= 1'b0;
      found_idx_q <= '0;
      found_ev_q <= '0;
      free_idx_q <= '0;
    end else if (cmd_i.step) begin
      if (!at_last) idx_q <= nxt_idx;
      if (m && !found_q) begin
        found_q <= 1'b1;
        found_idx_q <= idx_q;
        found_ev_q <= e_ev_q;
      end
      if (!e_valid && !free_q) begin
        free_q <= 1'b1;
        free_idx_q <= idx_q;
      end
    end
    if (cmd_i.finish) rsp_q <= rsp_d;
  end

  // Entry store: the first entry is fetched on load, the next one on each step until the last entry.
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      addr_mem[free_idx_q] <= req_q.address;
      len_mem[free_idx_q] <= req_q.access_len;
      wild_mem[free_idx_q] <= !req_q.match_data;
      val_mem[free_idx_q] <= req_q.match_data ? req_q.data_value : 64'd0;
      ev_mem[free_idx_q] <= req_q.event_id[EventIdBits-1:0];
    end
    if (cmd_i.load) begin
      e_addr_q <= addr_mem[FirstIdx];
      e_len_q <= len_mem[FirstIdx];
      e_wild_q <= wild_mem[FirstIdx];
      e_val_q <= val_mem[FirstIdx];
      e_ev_q <= ev_mem[FirstIdx];
    end else if (cmd_i.step && !at_last) begin
      e_addr_q <= addr_mem[nxt_idx];
      e_len_q <= len_mem[nxt_idx];
      e_wild_q <= wild_mem[nxt_idx];
      e_val_q <= val_mem[nxt_idx];
      e_ev_q <= ev_mem[nxt_idx];
    end
  end

  assign out_data_o = rsp_q;
  assign any_free_o = !(&valid_q);
endmodule

// ===== hdl/mmio_write_event_match_table.sv =====
// Top level of the trapped-write match table: controller, datapath and checks.
// A word is accepted in the idle state, the datapath scan then compares one entry
// per cycle, and the result is registered once the output register is free;
// invalid requests skip the scan. Only one word is handled at a time: no new word
// is accepted until the result of the last one has been registered.
// Reset clears all entry valid bits at once; entry contents stay unwritten.
module mmio_write_event_match_table #(
  parameter int unsigned TableEntries = mwem_pkg::TableEntriesDef,
  parameter int unsigned EventIdBits = mwem_pkg::EventIdBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mwem_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mwem_pkg::rsp_t out_data_o
);
`include "mmio_write_event_match_table_defines.svh"

  mwem_pkg::cmd_t cmd;
  mwem_pkg::sts_t sts;
  logic any_free;

  // The controller accepts a word only when idle, steps the scan once per entry
  // unless the word needs no scan, and holds the result in an output register until it is taken.
  mwem_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  // The datapath holds the entry store and compares the captured word
  // against one entry per cycle.
  mwem_datapath #(.TableEntries(TableEntries), .EventIdBits(EventIdBits)) u_dp (
    .clk_i, .rst_ni, .in_data_i, .out_data_o, .cmd_i(cmd), .sts_o(sts),
    .any_free_o(any_free)
  );

  // A result that is not taken stays at the output unchanged.
  `MWEM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  // A table-full answer only when no slot was free.
  `MWEM_ASSERT_IMPL(a_full_only_when_full,
    out_valid_o && out_data_o.status == mwem_pkg::StFull, !any_free)
  // A hit always comes with an ok status.
  `MWEM_ASSERT_IMPL(a_hit_ok, out_valid_o && out_data_o.hit, out_data_o.status == mwem_pkg::StOk)
  // Loading never coincides with a scan step or with finishing.
  `MWEM_ASSERT_IMPL(a_cmd_excl, cmd.load, !cmd.finish && !cmd.step)
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the trapped-write match table.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries = 16;
  // An unused operation code; the block must answer it as invalid.
  localparam logic [1:0] OpUnused = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  mwem_pkg::req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  mwem_pkg::rsp_t out_data_o;

  mmio_write_event_match_table i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // The table as the testbench believes it to be.
  logic        tbl_valid [Entries];
  logic [63:0] tbl_addr  [Entries];
  logic [3:0]  tbl_len   [Entries];
  logic        tbl_wild  [Entries];
  logic [63:0] tbl_value [Entries];
  logic [15:0] tbl_event [Entries];

  // Responses still owed by the block, oldest first.
  mwem_pkg::rsp_t pending_rsp[$];
  int   n_errors;
  // When set, both sides run without random idle cycles.
  bit   no_idle;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Random idling with a chance of about 37 in a hundred, unless switched off.
  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 37);
  endfunction

  function automatic logic [63:0] mask_for_len(input logic [3:0] len);
    case (len)
      4'd1: return 64'hff;
      4'd2: return 64'hffff;
      4'd4: return 64'hffff_ffff;
      default: return '1;
    endcase
  endfunction

  function automatic bit args_valid(input mwem_pkg::req_t r);
    logic [64:0] sum;
    sum = {1'b0, r.address} + 65'(r.access_len);
    if (!(r.access_len inside {4'd0, 4'd1, 4'd2, 4'd4, 4'd8})) return 0;
    if (sum[64]) return 0;
    if (r.unknown_flags) return 0;
    if (r.access_len == 4'd0 && r.match_data) return 0;
    if (r.port_io) return 0;
    return 1;
  endfunction

  function automatic bit clashes(input mwem_pkg::req_t r);
    logic wild;
    wild = !r.match_data;
    for (int i = 0; i < Entries; i++) begin
      if (!tbl_valid[i]) continue;
      if (tbl_addr[i] == r.address &&
          (tbl_len[i] == 0 || r.access_len == 0 ||
           (tbl_len[i] == r.access_len &&
            (tbl_wild[i] || wild || tbl_value[i] == r.data_value))))
        return 1;
      if (r.address >= tbl_addr[i] &&
          (r.address - tbl_addr[i]) < 64'(tbl_len[i]))
        return 1;
    end
    return 0;
  endfunction

  // Works out the response to one word and updates the table copy.
  function automatic mwem_pkg::rsp_t table_response(input mwem_pkg::req_t r);
    mwem_pkg::rsp_t o;
    int   slot;
    logic wild;
    bit   m;
    o = '0;
    o.status = mwem_pkg::StOk;
    wild = !r.match_data;
    if (r.operation == mwem_pkg::OpAssign || r.operation == mwem_pkg::OpDeassign) begin
      if (!args_valid(r)) begin
        o.status = mwem_pkg::StInvalid;
      end else if (r.operation == mwem_pkg::OpAssign) begin
        slot = -1;
        for (int i = 0; i < Entries; i++) begin
          if (!tbl_valid[i]) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) begin
          o.status = mwem_pkg::StFull;
        end else if (clashes(r)) begin
          o.status = mwem_pkg::StExists;
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_addr[slot]  = r.address;
          tbl_len[slot]   = r.access_len;
          tbl_wild[slot]  = wild;
          tbl_value[slot] = wild ? 64'd0 : r.data_value;
          tbl_event[slot] = r.event_id;
        end
      end else begin
        o.status = mwem_pkg::StNotFound;
        for (int i = 0; i < Entries; i++) begin
          if (!tbl_valid[i] || tbl_event[i] != r.event_id ||
              tbl_addr[i] != r.address || tbl_len[i] != r.access_len ||
              tbl_wild[i] != wild) continue;
          if (!wild && tbl_value[i] != r.data_value) continue;
          tbl_valid[i] = 1'b0;
          o.status = mwem_pkg::StOk;
          break;
        end
      end
    end else if (r.operation == mwem_pkg::OpLookup) begin
      for (int i = 0; i < Entries; i++) begin
        if (!tbl_valid[i] || tbl_addr[i] != r.address) continue;
        if (tbl_len[i] == 0) m = 1;
        else if (tbl_len[i] != r.access_len) m = 0;
        else if (tbl_wild[i]) m = 1;
        else m = (r.data_value & mask_for_len(r.access_len)) == tbl_value[i];
        if (m) begin
          o.hit = 1'b1;
          o.hit_event = tbl_event[i];
          break;
        end
      end
    end else begin
      o.status = mwem_pkg::StInvalid;
    end
    return o;
  endfunction

  // Sends one word: the prediction is made at the edge that accepts it.
  // Valid is left high on return, so the next call either replaces the word
  // or drops valid at the same falling edge.
  task automatic send_word(input mwem_pkg::req_t r);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rsp.push_back(table_response(r));
    @(negedge clk_i);
  endtask

  // Response side: random back-pressure, and a check of every response taken.
  initial begin
    mwem_pkg::rsp_t want;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= !idle_now();
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: unexpected response %p", $time, out_data_o);
          n_errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (out_data_o.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_data_o.status);
            n_errors++;
          end
          if (out_data_o.hit !== want.hit) begin
            $display("%0t: hit expected %0d actual %0d",
                     $time, want.hit, out_data_o.hit);
            n_errors++;
          end
          if (out_data_o.hit_event !== want.hit_event) begin
            $display("%0t: hit_event expected %h actual %h",
                     $time, want.hit_event, out_data_o.hit_event);
            n_errors++;
          end
        end
      end
    end
  end

  function automatic mwem_pkg::req_t make_word(input logic [1:0] op, input logic [63:0] a,
                                               input logic [3:0] len, input logic [63:0] d,
                                               input logic dm, input logic [15:0] ev);
    mwem_pkg::req_t r;
    r = '0;
    r.operation = op;
    r.address = a;
    r.access_len = len;
    r.data_value = d;
    r.match_data = dm;
    r.event_id = ev;
    return r;
  endfunction

  // Argument checks, the unused operation and the field extremes.
  task automatic test_argument_checks();
    mwem_pkg::req_t r;
    send_word(make_word(mwem_pkg::OpAssign, 64'h1000, 4'd3, 64'd0, 1'b1, 16'd1));
    send_word(make_word(mwem_pkg::OpAssign, 64'h1000, 4'd15, 64'd0, 1'b1, 16'd1));
    send_word(make_word(mwem_pkg::OpAssign, '1, 4'd1, 64'd0, 1'b1, 16'd1));
    send_word(make_word(mwem_pkg::OpAssign, 64'h2000, 4'd0, 64'd0, 1'b1, 16'd1));
    r = make_word(mwem_pkg::OpAssign, 64'h2000, 4'd4, 64'd0, 1'b1, 16'd1);
    r.port_io = 1'b1;
    send_word(r);
    r.port_io = 1'b0;
    r.unknown_flags = 1'b1;
    send_word(r);
    r = make_word(OpUnused, '1, 4'd8, '1, 1'b1, 16'hffff);
    r.port_io = 1'b1;
    r.unknown_flags = 1'b1;
    send_word(r);
    // An entry that ends right at the top of the address space is rejected as invalid.
    send_word(make_word(mwem_pkg::OpAssign, 64'hffff_ffff_ffff_fff8, 4'd8, '1, 1'b1,
                        16'hffff));
    send_word(make_word(mwem_pkg::OpLookup, 64'hffff_ffff_ffff_fff8, 4'd8, '1, 1'b0,
                        16'd0));
    send_word(make_word(mwem_pkg::OpDeassign, 64'hffff_ffff_ffff_fff8, 4'd8, '1, 1'b1,
                        16'hffff));
  endtask

  // Collisions, masked data match, wildcards, address-only entries, removal.
  task automatic test_match_rules();
    send_word(make_word(mwem_pkg::OpAssign, 64'h100, 4'd4, 64'h1234_5678, 1'b1, 16'h11));
    send_word(make_word(mwem_pkg::OpAssign, 64'h100, 4'd4, 64'h1234_5678, 1'b1, 16'h12));
    send_word(make_word(mwem_pkg::OpAssign, 64'h100, 4'd4, 64'h9999, 1'b0, 16'h13));
    send_word(make_word(mwem_pkg::OpAssign, 64'h102, 4'd1, 64'd0, 1'b0, 16'h14));
    send_word(make_word(mwem_pkg::OpAssign, 64'h100, 4'd2, 64'h55, 1'b1, 16'h15));
    send_word(make_word(mwem_pkg::OpLookup, 64'h100, 4'd4, 64'hffff_ffff_1234_5678, 1'b0,
                        16'd0));
    send_word(make_word(mwem_pkg::OpLookup, 64'h100, 4'd2, 64'h55, 1'b0, 16'd0));
    send_word(make_word(mwem_pkg::OpAssign, 64'h200, 4'd0, 64'd0, 1'b0, 16'h20));
    send_word(make_word(mwem_pkg::OpAssign, 64'h200, 4'd8, 64'd0, 1'b0, 16'h21));
    send_word(make_word(mwem_pkg::OpLookup, 64'h200, 4'd1, 64'hab, 1'b1, 16'd0));
    send_word(make_word(mwem_pkg::OpDeassign, 64'h100, 4'd4, 64'h1234_5678, 1'b1, 16'h99));
    send_word(make_word(mwem_pkg::OpDeassign, 64'h100, 4'd4, 64'h1234_5678, 1'b1, 16'h11));
    send_word(make_word(mwem_pkg::OpLookup, 64'h100, 4'd4, 64'h1234_5678, 1'b0, 16'd0));
  endtask

  // Fills the table to report it full, then removes the entries it added.
  task automatic test_full_table();
    for (int i = 0; i < Entries + 1; i++)
      send_word(make_word(mwem_pkg::OpAssign, 64'h8000 + 64'(16 * i), 4'd1, 64'd0, 1'b0,
                          16'(i)));
    for (int i = 0; i < Entries + 1; i++)
      send_word(make_word(mwem_pkg::OpDeassign, 64'h8000 + 64'(16 * i), 4'd1, 64'd0, 1'b0,
                          16'(i)));
  endtask

  // Random words on a small address pool so that entries meet each other.
  task automatic test_random_traffic(input int n_words);
    mwem_pkg::req_t r;
    logic [3:0] lens[5] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd8};
    for (int k = 0; k < n_words; k++) begin
      no_idle = (k >= n_words / 2) && (k < n_words / 2 + 100);
      r = '0;
      r.operation = 2'($urandom_range(99) < 40 ? mwem_pkg::OpLookup :
                       ($urandom_range(99) < 55 ? mwem_pkg::OpAssign : mwem_pkg::OpDeassign));
      if ($urandom_range(99) < 3) r.operation = OpUnused;
      r.address = ($urandom_range(99) < 8) ? {$urandom, $urandom}
                                           : 64'h4000 + 64'($urandom_range(31));
      r.access_len = ($urandom_range(99) < 5) ? 4'($urandom) : lens[$urandom_range(4)];
      r.data_value = ($urandom_range(1)) ? {$urandom, $urandom} : 64'($urandom_range(3));
      r.match_data = (r.access_len != 0) && $urandom_range(1);
      r.port_io = ($urandom_range(99) < 4);
      r.unknown_flags = ($urandom_range(99) < 4);
      r.event_id = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(3));
      send_word(r);
    end
    no_idle = 0;
  endtask

  initial begin
    n_errors = 0;
    no_idle = 0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    for (int i = 0; i < Entries; i++) tbl_valid[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_argument_checks();
    test_match_rules();
    test_full_table();
    test_random_traffic(900);
    in_valid_i <= 1'b0;
    // Drain the outstanding responses, then allow the block to settle.
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: ends with an error a run that has not finished in time.
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
